// File: rtl/core/biquad_df2t_cascade_filter_assert.svh
// ----------------------------------------------------------------------------
// biquad cascade assertion macros
// immediate-consequence and next-cycle checks, clocked, reset-qualified
// ----------------------------------------------------------------------------
`ifndef BIQUAD_DF2T_CASCADE_FILTER_ASSERT_SVH
`define BIQUAD_DF2T_CASCADE_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BQC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqc check failed");

// antecedent implies consequent in the next cycle
`define BQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqc check failed");

`endif

// File: rtl/core/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// shared constants, control codes and structs of the biquad cascade
// ----------------------------------------------------------------------------
package bqc_pkg;

    // sizing
    localparam int MAX_SECTIONS_DEF  = 8;
    localparam int WORDS_PER_SECTION = 7;
    localparam int SAMPLE_W          = 32;
    localparam int COEF_W            = 32;
    localparam int ACC_W             = 64;
    localparam int CFG_W             = 4;
    localparam int CFG_IDX_W         = 1;
    localparam int SEC_CNT_W         = 5;
    localparam int STEP_W            = 4;
    localparam int SHIFT_W           = 5;
    localparam int SHAMT_W           = 6;

    // fixed point formats
    localparam int ACC_FRAC    = 61;
    localparam int SAMPLE_FRAC = 31;
    localparam int GAIN_FRAC   = 45;
    localparam int Y_RND_SHIFT  = ACC_FRAC - SAMPLE_FRAC - 1;
    localparam int OUT_RND_BASE = GAIN_FRAC - SAMPLE_FRAC - 1;
    localparam int RND_W        = ACC_W - OUT_RND_BASE;

    // input item layout
    localparam int IDX_W        = 6;
    localparam int SAMPLE_LSB   = 0;
    localparam int IDX_LSB      = SAMPLE_LSB + SAMPLE_W;
    localparam int VAL_LSB      = IDX_LSB + IDX_W;
    localparam int IN_FIELDS_W  = VAL_LSB + COEF_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // word positions inside one section
    localparam logic [2:0] POS_A2 = 3'd0;
    localparam logic [2:0] POS_A1 = 3'd1;
    localparam logic [2:0] POS_B2 = 3'd2;
    localparam logic [2:0] POS_B1 = 3'd3;
    localparam logic [2:0] POS_B0 = 3'd4;
    localparam logic [2:0] POS_SH = 3'd5;
    localparam logic [2:0] POS_G  = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIQUAD_COUNT  = 1'b0,
        CFG_SERIES_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_B0,
        ACC_ND0_INIT,
        ACC_ND1_INIT,
        ACC_ND0_ADD,
        ACC_ND1_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        RND1_NONE,
        RND1_Y,
        RND1_OUT
    } rnd1_op_t;

    typedef enum logic [1:0] {
        RND2_NONE,
        RND2_Y,
        RND2_V
    } rnd2_op_t;

    typedef struct packed {
        logic     capture;
        logic     load_x;
        logic     mul_y;
        acc_op_t  acc_op;
        rnd1_op_t rnd1;
        rnd2_op_t rnd2;
        logic     sh_load;
        logic     d_write;
        logic     sum_clear;
        logic     sum_add;
    } dp_ctrl_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] sum;
    } dp_stat_t;

endpackage

// File: rtl/core/bqc_coef_mem.sv
// ----------------------------------------------------------------------------
// bqc_coef_mem
// coefficient word memory, one write and one registered read port,
// per-word valid bits so unwritten words read as zero after reset
// ----------------------------------------------------------------------------
module bqc_coef_mem #(
    parameter  int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
    localparam int TABLE_WORDS  = MAX_SECTIONS * bqc_pkg::WORDS_PER_SECTION,
    localparam int ADDR_W       = $clog2(TABLE_WORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [bqc_pkg::COEF_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [bqc_pkg::COEF_W-1:0]  rdata
);
    import bqc_pkg::*;

    logic [COEF_W-1:0] mem [TABLE_WORDS];
    logic              vld_reg [TABLE_WORDS];
    logic [COEF_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TABLE_WORDS; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    // never-written words read as their reset value
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: rtl/core/bqc_datapath.sv
// ----------------------------------------------------------------------------
// bqc_datapath
// shared 32x32 multiplier, 64-bit accumulate adder, two-stage round and
// saturate unit, section delay store and chain output summer
// ----------------------------------------------------------------------------
module bqc_datapath #(
    parameter  int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
    localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bqc_pkg::dp_ctrl_t                  ctrl,
    input  logic [SEC_W-1:0]                   sec,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [bqc_pkg::COEF_W-1:0]  coef,
    output bqc_pkg::dp_stat_t                  stat
);
    import bqc_pkg::*;

    logic [ACC_W-1:0] d0_mem [MAX_SECTIONS];
    logic [ACC_W-1:0] d1_mem [MAX_SECTIONS];

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] sum_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           nd0_reg;
    logic [ACC_W-1:0]           nd1_reg;
    logic signed [RND_W-1:0]    shf_reg;
    logic [SHIFT_W-1:0]         sh_reg;

    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [ACC_W-1:0]    prod_next;
    logic [ACC_W-1:0]           addend;
    logic [ACC_W-1:0]           acc_sum;
    logic signed [ACC_W-1:0]    rnd_src;
    logic [SHAMT_W-1:0]         rnd_amt;
    logic signed [ACC_W-1:0]    shifted_full;
    logic signed [RND_W:0]      rnd_inc;
    logic signed [RND_W-1:0]    rnd_q;
    logic signed [SAMPLE_W-1:0] rnd_sat;
    logic signed [SAMPLE_W:0]   sum_wide;
    logic signed [SAMPLE_W-1:0] sum_sat;
    logic [SHIFT_W-1:0]         sh_clamped;

    // one shared multiplier, product registered
    assign mul_b     = ctrl.mul_y ? y_reg : v_reg;
    assign prod_next = coef * mul_b;

    // accumulate adder, wraps modulo 2^64
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_B0:       addend = d0_mem[sec];
            ACC_ND0_INIT: addend = d1_mem[sec];
            ACC_ND0_ADD:  addend = nd0_reg;
            ACC_ND1_ADD:  addend = nd1_reg;
            default:      addend = '0;
        endcase
    end
    assign acc_sum = prod_reg + addend;

    // round stage one: arithmetic shift
    assign rnd_src      = (ctrl.rnd1 == RND1_Y) ? $signed(acc_reg) : prod_reg;
    assign rnd_amt      = (ctrl.rnd1 == RND1_Y) ? SHAMT_W'(Y_RND_SHIFT)
                                                : SHAMT_W'(OUT_RND_BASE) + SHAMT_W'(sh_reg);
    assign shifted_full = rnd_src >>> rnd_amt;

    // round stage two: add half, drop one bit, saturate to 32 bits
    assign rnd_inc = {shf_reg[RND_W-1], shf_reg} + (RND_W+1)'(1);
    assign rnd_q   = rnd_inc[RND_W:1];

    always_comb
    begin
        if ((&rnd_q[RND_W-1:SAMPLE_W-1]) || !(|rnd_q[RND_W-1:SAMPLE_W-1]))
        begin
            rnd_sat = rnd_q[SAMPLE_W-1:0];
        end
        else if (rnd_q[RND_W-1])
        begin
            rnd_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            rnd_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // chain summer with saturation
    assign sum_wide = {sum_reg[SAMPLE_W-1], sum_reg} + {v_reg[SAMPLE_W-1], v_reg};

    always_comb
    begin
        if (sum_wide[SAMPLE_W] == sum_wide[SAMPLE_W-1])
        begin
            sum_sat = sum_wide[SAMPLE_W-1:0];
        end
        else if (sum_wide[SAMPLE_W])
        begin
            sum_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // shift word clamped to 0..31
    always_comb
    begin
        if (coef[COEF_W-1])
        begin
            sh_clamped = '0;
        end
        else if (|coef[COEF_W-2:SHIFT_W])
        begin
            sh_clamped = '1;
        end
        else
        begin
            sh_clamped = coef[SHIFT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.capture)
        begin
            x_reg <= sample;
        end
        if (ctrl.load_x)
        begin
            v_reg <= x_reg;
        end
        else if (ctrl.rnd2 == RND2_V)
        begin
            v_reg <= rnd_sat;
        end
        if (ctrl.rnd2 == RND2_Y)
        begin
            y_reg <= rnd_sat;
        end
        case (ctrl.acc_op)
            ACC_B0:                     acc_reg <= acc_sum;
            ACC_ND0_INIT, ACC_ND0_ADD:  nd0_reg <= acc_sum;
            ACC_ND1_INIT, ACC_ND1_ADD:  nd1_reg <= acc_sum;
            default:                    ;
        endcase
        if (ctrl.rnd1 != RND1_NONE)
        begin
            shf_reg <= shifted_full[RND_W-1:0];
        end
        if (ctrl.sh_load)
        begin
            sh_reg <= sh_clamped;
        end
        if (ctrl.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sum_add)
        begin
            sum_reg <= sum_sat;
        end
    end

    // section delays, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_SECTIONS; n++)
            begin
                d0_mem[n] <= '0;
                d1_mem[n] <= '0;
            end
        end
        else if (ctrl.d_write)
        begin
            d0_mem[sec] <= nd0_reg;
            d1_mem[sec] <= nd1_reg;
        end
    end

    assign stat.x   = x_reg;
    assign stat.sum = sum_reg;

endmodule

// File: rtl/core/biquad_df2t_cascade_filter.sv
// ----------------------------------------------------------------------------
// biquad_df2t_cascade_filter
// bank of transposed direct form II biquads in series chains, chain outputs
// summed with saturation, Q1.31 samples in and out
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries one item: tuser = op (0 filter a sample, 1 write a
//    coefficient word), tdata = sample_in, coef_index, coef_value
//  - m_axis carries one filtered sample per filter item, none per write item
//  - cfg_we/cfg_index/cfg_data set biquad_count and series_length; write
//    them only while the block is idle
//  - a write item goes to the table on acceptance, the sequencer stays idle;
//    a bypass item (count zero) goes straight from idle to the output state
//  - a filter item runs, for each chain, a chain start, the steps of each
//    section in it and a chain add, then the output state; sections beyond
//    the bank pass without arithmetic; the one shared multiplier runs six
//    products per section and the a1/a2/gain products wait for the rounded y
//  - s_axis_tready is high only when the sequencer is idle
//  - the result sits in an output register; a stalled receiver holds it and
//    the next item can already be accepted; a new result waits for the
//    register to drain
//  - reset clears all delays, the coefficient table (valid bits), the
//    registers (count 0, series length 1) and the output valid flag
// ----------------------------------------------------------------------------
`include "biquad_df2t_cascade_filter_assert.svh"

module biquad_df2t_cascade_filter #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqc_pkg::CFG_W-1:0]         cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_in[31:0], coef_index[37:32], coef_value[69:38], zero pad
    input  logic [bqc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[0]
    input  logic [0:0]                        s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_out[31:0]
    output logic signed [bqc_pkg::SAMPLE_W-1:0] m_axis_tdata
);
    import bqc_pkg::*;

    localparam int TABLE_WORDS = MAX_SECTIONS * WORDS_PER_SECTION;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int SEC_W       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    // steps of one live section
    localparam logic [STEP_W-1:0] K_FETCH_B0 = 4'd0;  // read b0
    localparam logic [STEP_W-1:0] K_MUL_B0   = 4'd1;  // b0*in
    localparam logic [STEP_W-1:0] K_ACC_Y    = 4'd2;  // acc = b0*in + d0, b1*in
    localparam logic [STEP_W-1:0] K_RND_Y    = 4'd3;  // nd0 = b1*in + d1, b2*in
    localparam logic [STEP_W-1:0] K_SAT_Y    = 4'd4;  // nd1 = b2*in, y ready
    localparam logic [STEP_W-1:0] K_MUL_A1   = 4'd5;  // a1*y
    localparam logic [STEP_W-1:0] K_MUL_A2   = 4'd6;  // a2*y, nd0 += a1*y
    localparam logic [STEP_W-1:0] K_MUL_G    = 4'd7;  // gain*y, nd1 += a2*y
    localparam logic [STEP_W-1:0] K_RND_OUT  = 4'd8;  // shift gain product
    localparam logic [STEP_W-1:0] K_SAT_OUT  = 4'd9;  // section output, delays

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_SECT,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SEC_CNT_W-1:0]  s_reg, s_next;         // running section number
    logic [CFG_W-1:0]      i_reg, i_next;         // position inside the chain
    logic [CFG_W-1:0]      cnt_reg, cnt_next;     // clamped section count
    logic [CFG_W-1:0]      ser_reg, ser_next;     // chain length, never zero
    logic                  bypass_reg, bypass_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]   m_data_reg, m_data_next;

    logic [CFG_W-1:0]      count_cfg_reg;
    logic [CFG_W-1:0]      serlen_cfg_reg;

    dp_ctrl_t              ctrl;
    dp_stat_t              stat;
    logic [2:0]            rd_pos;
    logic [SEC_W-1:0]      sec_idx;
    logic [ADDR_W-1:0]     coef_raddr;
    logic [ADDR_W-1:0]     coef_waddr;
    logic                  coef_we;
    logic [COEF_W-1:0]     coef_rdata;

    logic                  in_accept;
    logic                  in_op;
    logic [IDX_W-1:0]      in_idx;
    logic                  sect_live;
    logic                  sect_done;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser[0];
    assign in_idx        = s_axis_tdata[IDX_LSB +: IDX_W];

    // coefficient word writes, indexes past the table are dropped
    assign coef_we    = in_accept && in_op && (int'(in_idx) < TABLE_WORDS);
    assign coef_waddr = ADDR_W'(in_idx);

    // sections at or past the bank size act as wires
    assign sec_idx    = s_reg[SEC_W-1:0];
    assign sect_live  = int'(s_reg) < MAX_SECTIONS;
    assign sect_done  = !sect_live || (step_reg == K_SAT_OUT);
    assign coef_raddr = ADDR_W'(int'(sec_idx) * WORDS_PER_SECTION + int'(rd_pos));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg  <= '0;
            serlen_cfg_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_BIQUAD_COUNT:  count_cfg_reg  <= cfg_data;
                CFG_SERIES_LENGTH: serlen_cfg_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_next       = s_reg;
        i_next       = i_reg;
        cnt_next     = cnt_reg;
        ser_next     = ser_reg;
        bypass_next  = bypass_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctrl         = '0;
        rd_pos       = POS_B0;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !in_op)
                begin
                    ctrl.capture = 1'b1;
                    if (count_cfg_reg == '0)
                    begin
                        bypass_next = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        bypass_next    = 1'b0;
                        cnt_next       = (int'(count_cfg_reg) > MAX_SECTIONS)
                                         ? CFG_W'(MAX_SECTIONS) : count_cfg_reg;
                        ser_next       = (serlen_cfg_reg == '0) ? CFG_W'(1) : serlen_cfg_reg;
                        s_next         = '0;
                        ctrl.sum_clear = 1'b1;
                        state_next     = ST_CHAIN;
                    end
                end
            end

            // a new chain starts at section number s while s is below the count
            ST_CHAIN:
            begin
                if (s_reg < SEC_CNT_W'(cnt_reg))
                begin
                    ctrl.load_x = 1'b1;
                    i_next      = '0;
                    step_next   = K_FETCH_B0;
                    state_next  = ST_SECT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_SECT:
            begin
                if (sect_live)
                begin
                    case (step_reg)
                        K_FETCH_B0:
                        begin
                            rd_pos = POS_B0;
                        end
                        K_MUL_B0:
                        begin
                            rd_pos = POS_B1;
                        end
                        K_ACC_Y:
                        begin
                            rd_pos      = POS_B2;
                            ctrl.acc_op = ACC_B0;
                        end
                        K_RND_Y:
                        begin
                            rd_pos      = POS_SH;
                            ctrl.acc_op = ACC_ND0_INIT;
                            ctrl.rnd1   = RND1_Y;
                        end
                        K_SAT_Y:
                        begin
                            rd_pos       = POS_A1;
                            ctrl.acc_op  = ACC_ND1_INIT;
                            ctrl.rnd2    = RND2_Y;
                            ctrl.sh_load = 1'b1;
                        end
                        K_MUL_A1:
                        begin
                            rd_pos     = POS_A2;
                            ctrl.mul_y = 1'b1;
                        end
                        K_MUL_A2:
                        begin
                            rd_pos      = POS_G;
                            ctrl.mul_y  = 1'b1;
                            ctrl.acc_op = ACC_ND0_ADD;
                        end
                        K_MUL_G:
                        begin
                            ctrl.mul_y  = 1'b1;
                            ctrl.acc_op = ACC_ND1_ADD;
                        end
                        K_RND_OUT:
                        begin
                            ctrl.rnd1 = RND1_OUT;
                        end
                        K_SAT_OUT:
                        begin
                            ctrl.rnd2    = RND2_V;
                            ctrl.d_write = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (sect_done)
                begin
                    s_next    = s_reg + SEC_CNT_W'(1);
                    step_next = K_FETCH_B0;
                    if (i_reg == ser_reg - CFG_W'(1))
                    begin
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        i_next = i_reg + CFG_W'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            ST_ADD:
            begin
                ctrl.sum_add = 1'b1;
                state_next   = ST_CHAIN;
            end

            // hand the result over once the output register is free
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = bypass_reg ? stat.x : stat.sum;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= K_FETCH_B0;
            s_reg       <= '0;
            i_reg       <= '0;
            cnt_reg     <= '0;
            ser_reg     <= CFG_W'(1);
            bypass_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            s_reg       <= s_next;
            i_reg       <= i_next;
            cnt_reg     <= cnt_next;
            ser_reg     <= ser_next;
            bypass_reg  <= bypass_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // coefficient table
    bqc_coef_mem #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_coef_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_axis_tdata[VAL_LSB +: COEF_W]),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // shared arithmetic
    bqc_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sec    (sec_idx),
        .sample (s_axis_tdata[SAMPLE_LSB +: SAMPLE_W]),
        .coef   (coef_rdata),
        .stat   (stat)
    );

    // checks
    // only the first step of a section may see a section number past the bank
    `BQC_ASSERT_IMPL(a_sect_in_bank, clk, rst_n, state_reg == ST_SECT && step_reg != K_FETCH_B0, int'(s_reg) < MAX_SECTIONS)
    // chain position never reaches the chain length
    `BQC_ASSERT_IMPL(a_chain_pos, clk, rst_n, state_reg == ST_SECT, i_reg < ser_reg)
    // a free output register always takes the pending result
    `BQC_ASSERT_NEXT(a_out_loaded, clk, rst_n, state_reg == ST_OUT && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && state_reg == ST_IDLE)

endmodule

// File: dv/bqc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bqc_tb_pkg
// scoreboard for the biquad cascade: keeps its own copy of the coefficient
// table, the section delays and the two registers, predicts every filtered
// sample and checks the samples coming out of the block in order
// ----------------------------------------------------------------------------
package bqc_tb_pkg;

    import bqc_pkg::*;

    localparam int N_SECT  = MAX_SECTIONS_DEF;
    localparam int N_WORDS = N_SECT * WORDS_PER_SECTION;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_WRITE  = 1'b1
    } item_op_t;

    class cascade_scoreboard;

        logic signed [COEF_W-1:0]   coef [N_WORDS];
        logic signed [ACC_W-1:0]    dly  [2 * N_SECT];
        logic [CFG_W-1:0]           n_biquads;
        logic [CFG_W-1:0]           chain_len;
        logic signed [SAMPLE_W-1:0] want_q [$];

        int errors;
        int checked;
        int saturated;
        int bypassed;
        int filters;
        int writes;

        function new();
            foreach (coef[i]) coef[i] = '0;
            foreach (dly[i]) dly[i] = '0;
            n_biquads = '0;
            chain_len = 4'd1;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            if (idx == CFG_BIQUAD_COUNT)
                n_biquads = val;
            else
                chain_len = val;
        endfunction

        function logic signed [SAMPLE_W-1:0] sat32(logic signed [ACC_W-1:0] v);
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[SAMPLE_W-1:0];
        endfunction

        // drop n bits, add half an lsb, drop one more, saturate
        function logic signed [SAMPLE_W-1:0] round_sat(logic signed [ACC_W-1:0] acc, int n);
            logic signed [ACC_W-1:0] r;
            r = (acc >>> n) + 64'sd1;
            r = r >>> 1;
            return sat32(r);
        endfunction

        function logic signed [SAMPLE_W-1:0] run_section(int s, logic signed [SAMPLE_W-1:0] x);
            logic signed [ACC_W-1:0]    c [WORDS_PER_SECTION];
            logic signed [ACC_W-1:0]    xi;
            logic signed [ACC_W-1:0]    yi;
            logic signed [ACC_W-1:0]    acc;
            logic signed [SAMPLE_W-1:0] y;
            int                         sh;
            for (int k = 0; k < WORDS_PER_SECTION; k++)
                c[k] = coef[s * WORDS_PER_SECTION + k];
            xi  = x;
            acc = c[POS_B0] * xi + dly[2 * s];
            y   = round_sat(acc, ACC_FRAC - SAMPLE_FRAC - 1);
            yi  = y;
            dly[2 * s]     = dly[2 * s + 1] + c[POS_B1] * xi + c[POS_A1] * yi;
            dly[2 * s + 1] = c[POS_B2] * xi + c[POS_A2] * yi;
            sh = coef[s * WORDS_PER_SECTION + POS_SH];
            if (sh < 0)
                sh = 0;
            if (sh > 31)
                sh = 31;
            return round_sat(c[POS_G] * yi, GAIN_FRAC + sh - SAMPLE_FRAC - 1);
        endfunction

        function logic signed [SAMPLE_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] x);
            int                         cnt;
            int                         ser;
            int                         s;
            logic signed [ACC_W-1:0]    total;
            logic signed [SAMPLE_W-1:0] v;
            if (n_biquads == 0) begin
                bypassed++;
                return x;
            end
            cnt   = (n_biquads > N_SECT) ? N_SECT : n_biquads;
            ser   = (chain_len == 0) ? 1 : chain_len;
            s     = 0;
            total = '0;
            for (int j = 0; j < cnt; j += ser) begin
                v = x;
                // sections past the bank pass the chain value through
                for (int i = 0; i < ser; i++) begin
                    if (s < N_SECT)
                        v = run_section(s, v);
                    s++;
                end
                total = sat32(total + v);
            end
            return total[SAMPLE_W-1:0];
        endfunction

        function void note_item(item_op_t op, logic signed [SAMPLE_W-1:0] smp,
                                logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
            if (op == OP_WRITE) begin
                writes++;
                if (idx < N_WORDS)
                    coef[idx] = val;
            end else begin
                filters++;
                want_q.push_back(filter_sample(smp));
            end
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (want_q.size() == 0) begin
                if (errors < 20)
                    $display("%0t: unexpected sample_out, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            checked++;
            if (got == 32'sh7FFFFFFF || got == 32'sh80000000)
                saturated++;
            if (got !== want) begin
                if (errors < 20)
                    $display("%0t: sample_out mismatch, expected %h, got %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void finish();
            if (want_q.size() != 0) begin
                $display("%0t: %0d samples never came out, expected next %h, got none",
                         $time, want_q.size(), want_q[0]);
                errors += want_q.size();
            end
        endfunction

    endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the biquad cascade: directed extremes and corner
// settings, then random phases of coefficient programming and sample bursts,
// each result checked against a scoreboard prediction, with random gaps and
// receiver stalls
// ----------------------------------------------------------------------------
module tb_top;

    import bqc_pkg::*;
    import bqc_tb_pkg::*;

    // run shape
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 130;
    // leave room for the slowest item to finish before touching registers
    localparam int DRAIN_SLACK = 120;
    // limit sized for the slowest legal run, roughly 1400 items with busy time, gaps and stalls
    localparam int LIMIT_CYCLES = 2500000;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    // sample_in, coef_index, coef_value from bit 0 up, zero pad on top
    logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;
    // op
    logic [0:0]                  s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // sample_out
    logic signed [SAMPLE_W-1:0]  m_axis_tdata;

    cascade_scoreboard sb;
    bit  quiet;            // no gaps, no stalls while set
    int  n_settings;
    int  cycles;

    biquad_df2t_cascade_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, counts every cycle of the run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // idle length: mostly none or short, a few long enough to land anywhere
    // in the processing of one item
    function automatic int pick_idle();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(40, 150);
    endfunction

    // receiver: checks each accepted result, stalls at random
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_sample(m_axis_tdata);
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 99) < 30)
                hold = pick_idle();
            m_axis_tready <= (hold == 0);
        end
    end

    // one input item: optional gap, then hold it until accepted
    task automatic push_item(item_op_t op, logic signed [SAMPLE_W-1:0] smp,
                             logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, idx, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(op, smp, idx, val);
    endtask

    task automatic filter(logic signed [SAMPLE_W-1:0] smp);
        push_item(OP_FILTER, smp, IDX_W'($urandom), $urandom);
    endtask

    task automatic write_word(int idx, logic signed [COEF_W-1:0] val);
        push_item(OP_WRITE, $urandom, IDX_W'(idx), val);
    endtask

    // sender holds off until every expected sample has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // registers change only with the block idle: drained, plus time for a
    // trailing coefficient write to finish
    task automatic set_regs(logic [CFG_W-1:0] cnt, logic [CFG_W-1:0] ser);
        hold_until_drained();
        repeat (DRAIN_SLACK) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BIQUAD_COUNT;
        cfg_data  <= cnt;
        @(posedge clk);
        sb.set_reg(CFG_BIQUAD_COUNT, cnt);
        cfg_index <= CFG_SERIES_LENGTH;
        cfg_data  <= ser;
        @(posedge clk);
        sb.set_reg(CFG_SERIES_LENGTH, ser);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic int spread(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        if (r < 55)
            return $urandom;
        return spread(1 << 28);
    endfunction

    // full coefficient set for one section; feedback kept small enough for
    // stable poles, shift and gain now and then out of the usual range
    task automatic program_section(int sect);
        int base;
        base = sect * WORDS_PER_SECTION;
        write_word(base + POS_A2, spread(1 << 29));
        write_word(base + POS_A1, spread(1 << 29));
        write_word(base + POS_B2, spread(1 << 29));
        write_word(base + POS_B1, spread(1 << 29));
        if ($urandom_range(0, 3) == 0)
            write_word(base + POS_B0, 32'sh40000000);
        else
            write_word(base + POS_B0, spread(1 << 29));
        if ($urandom_range(0, 5) == 0)
            write_word(base + POS_SH, $urandom);
        else
            write_word(base + POS_SH, $urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0)
            write_word(base + POS_G, $urandom);
        else
            write_word(base + POS_G, spread(1 << 15));
    endtask

    // one random phase: section programming, raw writes as noise, sample
    // bursts, and one full drain half way through
    task automatic run_phase(int budget);
        int  sent;
        int  r;
        int  burst;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                program_section($urandom_range(0, N_SECT - 1));
                sent += WORDS_PER_SECTION;
            end
            else if (r < 32)
            begin
                push_item(OP_WRITE, $urandom, IDX_W'($urandom), $urandom);
                sent++;
            end
            else
            begin
                burst = $urandom_range(1, 12);
                repeat (burst) filter(pick_sample());
                sent += burst;
            end
            if (!paused && sent >= budget / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] cnt;
        logic [CFG_W-1:0] ser;
        sb = new();
        n_settings = 0;
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass right after reset
        filter(32'sh7FFFFFFF);
        filter(32'sh80000000);

        // section 0 as a unity pass with a negative shift word (used as 0),
        // writes past the table end, last word of the table
        write_word(POS_B0, 32'sh40000000);
        write_word(POS_SH, -32'sd5);
        write_word(POS_G, 32'sd16384);
        write_word(56, 32'sh12345678);
        write_word(63, -32'sd1);
        write_word(55, 32'sh7FFFFFFF);

        set_regs(4'd1, 4'd1);
        filter(32'sh7FFFFFFF);
        filter(32'sh80000000);

        // shift word above 31 and extreme feedforward/feedback words push
        // the accumulators and stored delays through wraparound
        write_word(POS_SH, 32'sd40);
        write_word(POS_B1, 32'sh80000000);
        write_word(POS_A1, 32'sh80000000);
        write_word(POS_B0, 32'sh7FFFFFFF);
        filter(32'sh80000000);
        filter(32'sh7FFFFFFF);

        // count above the bank with series length zero
        set_regs(4'd15, 4'd0);
        filter(32'sd1);
        // count not a multiple of the series length
        set_regs(4'd3, 4'd2);
        filter(32'sh40000000);
        // chain running past the last section of the bank
        set_regs(4'd8, 4'd15);
        filter(-32'sd12345);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: begin cnt = 4'd8;  ser = 4'd1;  end
                1: begin cnt = 4'd15; ser = 4'd15; end
                2: begin cnt = 4'd0;  ser = 4'd3;  end
                3: begin cnt = 4'd4;  ser = 4'd2;  end
                4: begin cnt = 4'd5;  ser = 4'd0;  end
                default:
                begin
                    cnt = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
                    ser = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 4) : $urandom_range(0, 15);
                end
            endcase
            set_regs(cnt, ser);
            quiet = (ph % 4 == 3);
            run_phase(PHASE_ITEMS);
        end
        quiet = 1'b0;

        // let the last results out, then some quiet time
        hold_until_drained();
        repeat (DRAIN_SLACK) @(posedge clk);
        sb.finish();

        $display("run covered %0d filter items and %0d coefficient writes over %0d register settings",
                 sb.filters, sb.writes, n_settings);
        $display("%0d samples checked, %0d in bypass, %0d at a saturation limit",
                 sb.checked, sb.bypassed, sb.saturated);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
